>>> rtl/spt_pkg.sv
package spt_pkg;

    localparam int RangeW = 12;
    localparam int RegW   = 14;

    typedef enum logic [3:0] {
        K_TICK      = 4'd0,
        K_UP        = 4'd1,
        K_DOWN      = 4'd2,
        K_STOP      = 4'd3,
        K_STOP_TILT = 4'd4,
        K_GOTO      = 4'd5,
        K_SET_TILT  = 4'd6,
        K_TILT_UP   = 4'd7,
        K_TILT_DOWN = 4'd8,
        K_RESYNC    = 4'd9
    } kind_t;

    localparam logic [1:0] TILT_CLOSED = 2'd0;
    localparam logic [1:0] TILT_HALF   = 2'd1;
    localparam logic [1:0] TILT_OPEN   = 2'd2;
    localparam logic [1:0] TILT_UNSET  = 2'd3;

    localparam logic [2:0] REG_TRAVEL  = 3'd0;
    localparam logic [2:0] REG_TFULL   = 3'd1;
    localparam logic [2:0] REG_THALF   = 3'd2;
    localparam logic [2:0] REG_REVERSE = 3'd3;
    localparam logic [2:0] REG_TWAIT   = 3'd4;
    localparam logic [2:0] REG_STEP    = 3'd5;

    typedef struct packed {
        logic up;
        logic dn;
        logic jog_up;
        logic jog_dn;
        logic sync;
        logic tilting;
        logic jog_dir_up;
        logic reported;
        logic move_after;
    } flags_t;

    typedef struct packed {
        logic stop;
        logic tstop;
        logic sup;
        logic sdn;
    } events_t;

endpackage

>>> rtl/shade_position_tilt_controller_core.sv
// channel | dir | fields (tdata from bit 0)
// s_axis  | in  | kind[3:0], target_percent[10:4], tilt_value[12:11]
// m_axis  | out | drive_up, drive_down, report_valid, reached_percent[9:3],
//         |     | is_synced[10], tilt_target[12:11], stopped, tilt_stopped,
//         |     | started_up, started_down [16:13]
// cfg     | in  | cfg_we, cfg_addr, cfg_data
// one item per cycle; the full update is one combinational pass from state regs
// the result sits in an output register; a new item is taken while it is free
// or being drained in the same cycle
// reset puts state to its initial values and loads register defaults
module shade_position_tilt_controller_core
    import spt_pkg::*;
#(
    parameter int TIMER_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [13:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // kind, target_percent, tilt_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // drive_up, drive_down, report_valid,
                                        // reached_percent, is_synced, tilt_target,
                                        // four events
);

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [7:0]      travel_reg;
    logic [RegW-1:0] tfull_reg, thalf_reg, rev_reg, twait_reg, step_reg;

    logic [RangeW-1:0] pos_reg, dpos_reg, ppos_reg;
    flags_t            fl_reg;
    logic [1:0]        dtilt_reg, ptilt_reg;
    logic [RegW-1:0]   run_len_reg;
    logic [TIMER_BITS-1:0] tel_reg [4];
    logic [3:0]        tf_reg;
    logic [6:0]        reached_reg;

    logic [RangeW-1:0] pos_next, dpos_next, ppos_next;
    flags_t            fl_next;
    logic [1:0]        dtilt_next, ptilt_next;
    logic [RegW-1:0]   run_len_next;
    logic [TIMER_BITS-1:0] tel_next [4];
    logic [3:0]        tf_next;
    logic [6:0]        reached_next;
    events_t           ev;
    logic              rep;
    logic [6:0]        pct;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    logic [3:0] kind;
    logic [6:0] tgt;
    logic [1:0] tv;
    assign kind = s_axis_tdata[3:0];
    assign tgt  = s_axis_tdata[10:4];
    assign tv   = s_axis_tdata[12:11];

    logic [RangeW-1:0] range_w, quarter_w;
    assign range_w   = RangeW'({travel_reg, 3'b000}) + RangeW'({travel_reg, 1'b0});
    assign quarter_w = range_w >> 2;

    function automatic logic [RangeW-1:0] sec_of(input logic [2:0] k,
                                                 input logic [RangeW-1:0] r,
                                                 input logic [RangeW-1:0] q);
        logic [RangeW-1:0] v;
        begin
            case (k)
                3'd0:    v = '0;
                3'd1:    v = q;
                3'd2:    v = {q[RangeW-2:0], 1'b0};
                3'd3:    v = {q[RangeW-2:0], 1'b0} + q;
                default: v = r;
            endcase
            return v;
        end
    endfunction

    always_comb
    begin
        logic mu, md, fire, moving;
        logic [1:0] old_t, t, p;
        logic [1:0] diff;
        logic [2:0] k;
        logic [RangeW-1:0] tp;
        logic [RangeW-1:0] stop_pos;
        logic do_goto;
        logic call_set, call_stop, call_end, call_fup, call_fdn;
        pos_next     = pos_reg;
        dpos_next    = dpos_reg;
        ppos_next    = ppos_reg;
        fl_next      = fl_reg;
        dtilt_next   = dtilt_reg;
        ptilt_next   = ptilt_reg;
        run_len_next = run_len_reg;
        for (int i = 0; i < 4; i++)
        begin
            tel_next[i] = tel_reg[i];
        end
        tf_next      = tf_reg;
        reached_next = reached_reg;
        ev           = '0;
        rep          = 1'b0;
        pct          = '0;
        mu = 1'b0; md = 1'b0; fire = 1'b0; moving = 1'b0;
        old_t = '0; t = '0; p = '0; diff = '0; k = '0; tp = '0; do_goto = 1'b0;
        stop_pos = '0;
        call_set = 1'b0; call_stop = 1'b0; call_end = 1'b0;
        call_fup = 1'b0; call_fdn = 1'b0;

        case (kind)
            K_TICK:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (tel_next[i] != TMAX)
                    begin
                        tel_next[i] = tel_next[i] + 1'b1;
                    end
                end
                if (32'(tel_next[0]) > 32'(rev_reg) && !tf_next[0])
                begin
                    tf_next[0] = 1'b1;
                    dpos_next  = ppos_next;
                end
                if (32'(tel_next[1]) > 32'(twait_reg) && !tf_next[1])
                begin
                    tf_next[1] = 1'b1;
                    fl_next.tilting = 1'b1;
                    if (fl_next.jog_dir_up)
                    begin
                        fl_next.jog_up = 1'b1;
                    end
                    else
                    begin
                        fl_next.jog_dn = 1'b1;
                    end
                    tel_next[2] = '0;
                    tf_next[2]  = 1'b0;
                end
                if (32'(tel_next[2]) > 32'(run_len_next) && !tf_next[2])
                begin
                    tf_next[2] = 1'b1;
                    call_stop  = 1'b1;
                end
                if (call_stop)
                begin
                    // tilt_stop; nested set_tilt sees tilting cleared
                    fl_next.up = 1'b0; fl_next.dn = 1'b0;
                    fl_next.jog_up = 1'b0; fl_next.jog_dn = 1'b0;
                    ev.tstop = 1'b1;
                    fl_next.tilting = 1'b0;
                    if (ptilt_next != TILT_UNSET)
                    begin
                        p = ptilt_next;
                        ptilt_next = TILT_UNSET;
                        old_t = dtilt_next;
                        dtilt_next = p;
                        if (old_t != p)
                        begin
                            if (pos_next == '0)
                            begin
                                ev.tstop = 1'b1;
                                if (fl_next.move_after)
                                begin
                                    tel_next[0] = '0; tf_next[0] = 1'b0;
                                    fl_next.move_after = 1'b0;
                                end
                            end
                            else
                            begin
                                diff = (p > old_t) ? p - old_t : old_t - p;
                                run_len_next = (diff == 2'd2) ? tfull_reg : thalf_reg;
                                fl_next.jog_dir_up = (p < old_t);
                                tel_next[1] = '0; tf_next[1] = 1'b0;
                            end
                        end
                    end
                    if (fl_next.move_after)
                    begin
                        tel_next[0] = '0; tf_next[0] = 1'b0;
                        fl_next.move_after = 1'b0;
                    end
                end
                if (32'(tel_next[3]) > 32'(step_reg) && !tf_next[3])
                begin
                    tf_next[3] = 1'b1;
                    fire = 1'b1;
                end
            end
            default: ;
        endcase

        // step_position
        call_stop = 1'b0;
        if (fire)
        begin
            mu = fl_next.up;
            md = fl_next.dn;
            if (!fl_next.sync)
            begin
                if (mu && pos_next != '0)
                begin
                    pos_next = pos_next - 1'b1; fl_next.reported = 1'b0;
                end
                else if (mu)
                begin
                    fl_next.sync = 1'b1; call_end = 1'b1; call_stop = 1'b1;
                    stop_pos = pos_next;
                end
                if (md && pos_next < range_w)
                begin
                    pos_next = pos_next + 1'b1; fl_next.reported = 1'b0;
                end
                else if (md && pos_next == range_w)
                begin
                    fl_next.sync = 1'b1; call_end = 1'b1; call_fdn = 1'b1;
                    stop_pos = pos_next;
                end
            end
            else if (!fl_next.tilting)
            begin
                if (pos_next > dpos_next)
                begin
                    if (!mu)
                    begin
                        fl_next.up = 1'b1; ev.sup = 1'b1;
                    end
                    pos_next = pos_next - 1'b1; fl_next.reported = 1'b0;
                end
                else if (mu && pos_next == dpos_next)
                begin
                    call_end = 1'b1;
                    stop_pos = pos_next;
                    if (pos_next != '0)
                    begin
                        call_fup = 1'b1;
                    end
                    else
                    begin
                        call_stop = 1'b1;
                    end
                end
                if (pos_next < dpos_next)
                begin
                    if (!md)
                    begin
                        fl_next.dn = 1'b1; ev.sdn = 1'b1;
                    end
                    pos_next = pos_next + 1'b1; fl_next.reported = 1'b0;
                end
                else if (md && pos_next == dpos_next)
                begin
                    call_end = 1'b1; call_fdn = 1'b1;
                    stop_pos = pos_next;
                end
            end
            if (call_end)
            begin
                fl_next.up = 1'b0; fl_next.dn = 1'b0;
                fl_next.jog_up = 1'b0; fl_next.jog_dn = 1'b0;
                ev.stop = 1'b1;
                fl_next.tilting = 1'b0;
                dpos_next = stop_pos;
            end
            if (call_stop)
            begin
                // only reached at position zero, the upper end, so a pending tilt never jogs
                ev.tstop = 1'b1;
                if (ptilt_next != TILT_UNSET)
                begin
                    p = ptilt_next;
                    ptilt_next = TILT_UNSET;
                    old_t = dtilt_next;
                    dtilt_next = p;
                end
                if (fl_next.move_after)
                begin
                    tel_next[0] = '0; tf_next[0] = 1'b0;
                    fl_next.move_after = 1'b0;
                end
            end
            if (call_fup)
            begin
                if (dtilt_next == TILT_OPEN)
                begin
                    run_len_next = tfull_reg; fl_next.jog_dir_up = 1'b0;
                    tel_next[1] = '0; tf_next[1] = 1'b0;
                end
                else if (dtilt_next == TILT_HALF)
                begin
                    run_len_next = thalf_reg; fl_next.jog_dir_up = 1'b0;
                    tel_next[1] = '0; tf_next[1] = 1'b0;
                end
            end
            if (call_fdn)
            begin
                if (dtilt_next == TILT_HALF)
                begin
                    run_len_next = thalf_reg; fl_next.jog_dir_up = 1'b1;
                    tel_next[1] = '0; tf_next[1] = 1'b0;
                end
                else if (dtilt_next == TILT_CLOSED)
                begin
                    run_len_next = tfull_reg; fl_next.jog_dir_up = 1'b1;
                    tel_next[1] = '0; tf_next[1] = 1'b0;
                end
            end
            tel_next[3] = '0;
            tf_next[3]  = 1'b0;
            if (fl_next.sync && !fl_next.reported)
            begin
                if (pos_next == '0)
                begin
                    rep = 1'b1; pct = 7'd0;
                end
                else if (pos_next == quarter_w)
                begin
                    rep = 1'b1; pct = 7'd25;
                end
                else if (pos_next == {quarter_w[RangeW-2:0], 1'b0})
                begin
                    rep = 1'b1; pct = 7'd50;
                end
                else if (pos_next == {quarter_w[RangeW-2:0], 1'b0} + quarter_w)
                begin
                    rep = 1'b1; pct = 7'd75;
                end
                else if (pos_next == range_w)
                begin
                    rep = 1'b1; pct = 7'd100;
                end
                if (rep)
                begin
                    reached_next = pct;
                    fl_next.reported = 1'b1;
                end
            end
        end

        // commands
        case (kind)
            K_UP:
            begin
                k = 3'd0; do_goto = 1'b1;
            end
            K_DOWN:
            begin
                k = 3'd4; do_goto = 1'b1;
            end
            K_GOTO:
            begin
                case (tgt)
                    7'd0:    begin k = 3'd0; do_goto = 1'b1; end
                    7'd25:   begin k = 3'd1; do_goto = 1'b1; end
                    7'd50:   begin k = 3'd2; do_goto = 1'b1; end
                    7'd75:   begin k = 3'd3; do_goto = 1'b1; end
                    7'd100:  begin k = 3'd4; do_goto = 1'b1; end
                    default: ;
                endcase
            end
            K_STOP, K_STOP_TILT:
            begin
                mu = fl_next.up; md = fl_next.dn;
                fl_next.up = 1'b0; fl_next.dn = 1'b0;
                fl_next.jog_up = 1'b0; fl_next.jog_dn = 1'b0;
                ev.stop = 1'b1;
                fl_next.tilting = 1'b0;
                dpos_next = pos_next;
                if (kind == K_STOP_TILT)
                begin
                    if (mu && (dtilt_next == TILT_OPEN || dtilt_next == TILT_HALF))
                    begin
                        run_len_next = (dtilt_next == TILT_OPEN) ? tfull_reg : thalf_reg;
                        fl_next.jog_dir_up = 1'b0;
                        tel_next[1] = '0; tf_next[1] = 1'b0;
                    end
                    if (md && (dtilt_next == TILT_HALF || dtilt_next == TILT_CLOSED))
                    begin
                        run_len_next = (dtilt_next == TILT_CLOSED) ? tfull_reg : thalf_reg;
                        fl_next.jog_dir_up = 1'b1;
                        tel_next[1] = '0; tf_next[1] = 1'b0;
                    end
                end
            end
            K_SET_TILT:
            begin
                if (tv != TILT_UNSET)
                begin
                    t = tv; call_set = 1'b1;
                end
            end
            K_TILT_UP:
            begin
                call_set = 1'b1;
                t = (dtilt_next == TILT_OPEN) ? TILT_HALF :
                    (dtilt_next == TILT_HALF) ? TILT_CLOSED : TILT_OPEN;
            end
            K_TILT_DOWN:
            begin
                call_set = 1'b1;
                t = (dtilt_next == TILT_OPEN) ? TILT_CLOSED :
                    (dtilt_next == TILT_CLOSED) ? TILT_HALF : TILT_OPEN;
            end
            K_RESYNC:
            begin
                fl_next.up = 1'b0; fl_next.dn = 1'b0;
                fl_next.jog_up = 1'b0; fl_next.jog_dn = 1'b0;
                fl_next.sync = 1'b0; fl_next.tilting = 1'b0;
                dtilt_next = TILT_HALF;
            end
            default: ;
        endcase

        if (do_goto)
        begin
            tp = sec_of(k, range_w, quarter_w);
            if (fl_next.dn && pos_next <= tp)
            begin
                dpos_next = tp;
            end
            else if (fl_next.dn)
            begin
                ppos_next = tp; tel_next[0] = '0; tf_next[0] = 1'b0;
                fl_next.dn = 1'b0; fl_next.jog_dn = 1'b0; dpos_next = pos_next;
            end
            else if (fl_next.up && pos_next <= tp)
            begin
                ppos_next = tp; tel_next[0] = '0; tf_next[0] = 1'b0;
                fl_next.up = 1'b0; fl_next.jog_up = 1'b0; dpos_next = pos_next;
            end
            else if (fl_next.up || !fl_next.tilting)
            begin
                dpos_next = tp;
            end
            else
            begin
                ppos_next = tp; fl_next.move_after = 1'b1;
            end
            if (kind == K_UP && !fl_next.sync)
            begin
                pos_next = range_w; fl_next.up = 1'b1; ev.sup = 1'b1;
            end
            if (kind == K_DOWN && !fl_next.sync)
            begin
                pos_next = '0; fl_next.dn = 1'b1; ev.sdn = 1'b1;
            end
        end

        if (call_set)
        begin
            if (fl_next.tilting)
            begin
                ptilt_next = t;
            end
            else
            begin
                old_t = dtilt_next;
                dtilt_next = t;
                moving = fl_next.up || fl_next.dn;
                if (old_t != t && !moving)
                begin
                    if (pos_next == '0)
                    begin
                        fl_next.up = 1'b0; fl_next.dn = 1'b0;
                        fl_next.jog_up = 1'b0; fl_next.jog_dn = 1'b0;
                        ev.tstop = 1'b1;
                        fl_next.tilting = 1'b0;
                        if (fl_next.move_after)
                        begin
                            tel_next[0] = '0; tf_next[0] = 1'b0;
                            fl_next.move_after = 1'b0;
                        end
                    end
                    else
                    begin
                        diff = (t > old_t) ? t - old_t : old_t - t;
                        run_len_next = (diff == 2'd2) ? tfull_reg : thalf_reg;
                        fl_next.jog_dir_up = (t < old_t);
                        tel_next[1] = '0; tf_next[1] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg <= 8'd30;
            tfull_reg  <= RegW'(1000);
            thalf_reg  <= RegW'(500);
            rev_reg    <= RegW'(300);
            twait_reg  <= RegW'(500);
            step_reg   <= RegW'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TRAVEL:  travel_reg <= cfg_data[7:0];
                REG_TFULL:   tfull_reg  <= cfg_data;
                REG_THALF:   thalf_reg  <= cfg_data;
                REG_REVERSE: rev_reg    <= cfg_data;
                REG_TWAIT:   twait_reg  <= cfg_data;
                REG_STEP:    step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            dpos_reg      <= '0;
            ppos_reg      <= '0;
            fl_reg        <= '0;
            dtilt_reg     <= TILT_HALF;
            ptilt_reg     <= TILT_UNSET;
            run_len_reg   <= RegW'(500);
            for (int i = 0; i < 4; i++)
            begin
                tel_reg[i] <= '0;
            end
            tf_reg        <= 4'b0111;
            reached_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                pos_reg       <= pos_next;
                dpos_reg      <= dpos_next;
                ppos_reg      <= ppos_next;
                fl_reg        <= fl_next;
                dtilt_reg     <= dtilt_next;
                ptilt_reg     <= ptilt_next;
                run_len_reg   <= run_len_next;
                for (int i = 0; i < 4; i++)
                begin
                    tel_reg[i] <= tel_next[i];
                end
                tf_reg        <= tf_next;
                reached_reg   <= reached_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= {7'd0, ev.sdn, ev.sup, ev.tstop, ev.stop, dtilt_next,
                                  fl_next.sync, pct, rep,
                                  fl_next.dn || fl_next.jog_dn,
                                  fl_next.up || fl_next.jog_up};
            end
        end
    end

endmodule
